// ===== rtl/thp_pkg.sv =====
// ----------------------------------------------------------------------------
// thp_pkg
// Shared types and constants of the Teredo header parser: the byte item, the
// per-payload summary and the protocol constants used to walk the headers.
// ----------------------------------------------------------------------------
package thp_pkg;

	localparam int COUNT_BITS_DEF = 16;

	// Header layout
	localparam logic [7:0]  AUTH_MARK_HI  = 8'h00;
	localparam logic [7:0]  AUTH_MARK_LO  = 8'h01;
	localparam logic [9:0]  PARKED_END    = 10'h3FF;
	localparam int          AUTH_FIXED    = 4;   // marker plus two length bytes
	localparam int          AUTH_TAIL     = 9;   // nonce plus confirmation byte
	localparam int          FIELD_SPAN    = 8;   // nonce or origin indication
	localparam int          ORIGIN_NH_OFS = 6;   // next header seen right after headers
	localparam int          INNER_NH_OFS  = 14;  // next header after an origin indication
	localparam int          IPV6_HDR_LEN  = 40;
	localparam logic [7:0]  NH_NO_NEXT    = 8'd59;
	localparam logic [3:0]  IPV6_VERSION  = 4'd6;
	localparam logic [15:0] PORT_MASK     = 16'hFFFF;
	localparam logic [31:0] ADDR_MASK     = 32'hFFFFFFFF;

	typedef enum logic [1:0] {
		OUT_SHORT      = 2'd0,
		OUT_AUTH_TRUNC = 2'd1,
		OUT_PARSED     = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_payload;
	} byte_item_t;

	typedef struct packed {
		outcome_t    outcome;
		logic        auth_seen;
		logic [7:0]  client_id_length;
		logic [7:0]  auth_value_length;
		logic [63:0] nonce;
		logic [7:0]  confirmation;
		logic        origin_seen;
		logic [15:0] origin_port;
		logic [31:0] origin_address;
		logic        ipv6_seen;
		logic        bubble;
	} summary_t;

endpackage

// ===== rtl/thp_if.sv =====
// ----------------------------------------------------------------------------
// thp_if
// Valid/ready channels of the Teredo header parser: the payload byte stream
// and the per-payload summary stream.
// ----------------------------------------------------------------------------
interface thp_byte_if import thp_pkg::*; ();
	logic       valid;
	logic       ready;
	byte_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface thp_summary_if import thp_pkg::*; ();
	logic     valid;
	logic     ready;
	summary_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/teredo_header_parser.sv =====
// ----------------------------------------------------------------------------
// teredo_header_parser
// Walks a UDP payload byte by byte and reports one summary per payload:
// authentication header, origin indication, inner IPv6 version and bubble.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                          transfer
//  payload   sink       data_byte, end_of_payload        valid && ready
//  summary   source     outcome .. bubble (summary_t)    valid && ready
//
//  One byte is taken per cycle while the input stage is not held; the parse state
//  updates in the single stage between the input register and the summary register.
//  A summary is written to the summary register as the end-marked byte leaves the input stage.
//  arst_n clears the input stage, the summary register and all parse state.
//  While a summary waits, non-final bytes keep flowing; only an end-marked
//  byte that finds the summary register still full holds the input stage.
//
module teredo_header_parser import thp_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	thp_byte_if.sink      payload,
	thp_summary_if.source summary
);

	typedef enum logic [2:0] {
		PH_LEAD     = 3'b001,
		PH_AUTH_LEN = 3'b010,
		PH_BODY     = 3'b100
	} phase_t;

	// One bit of headroom keeps offsets from the header end from wrapping.
	localparam int W = COUNT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Input stage
	logic       v_s1;
	byte_item_t item_s1;

	// Summary register
	logic     res_v_s2;
	summary_t res_s2;

	// Parse state
	logic [COUNT_BITS-1:0] pos_q;
	phase_t      phase_q;
	logic [7:0]  first_byte_q;
	logic [7:0]  len_hi_q;
	logic [7:0]  len_lo_q;
	logic [9:0]  skip_q;
	logic [63:0] nonce_q;
	logic [7:0]  confirm_q;
	logic [47:0] origin_q;
	logic [9:0]  hdr_end_q;
	logic        auth_q;
	logic        mark_bad_q;
	logic        v6_direct_q;
	logic        v6_after_q;
	logic [7:0]  nh_q;

	// Next-state values for the byte in the input stage
	phase_t      n_phase;
	logic [7:0]  n_first_byte;
	logic [7:0]  n_len_hi;
	logic [7:0]  n_len_lo;
	logic [9:0]  n_skip;
	logic [63:0] n_nonce;
	logic [7:0]  n_confirm;
	logic [47:0] n_origin;
	logic [9:0]  n_hdr_end;
	logic        n_auth;
	logic        n_mark_bad;
	logic        n_v6_direct;
	logic        n_v6_after;
	logic [7:0]  n_nh;
	logic [COUNT_BITS-1:0] n_pos;

	logic     stall_s1;
	logic     adv_s1;
	summary_t res_d;

	// Hold the input stage only when an end-marked byte cannot reach the
	// summary register.
	always_comb begin
		stall_s1      = v_s1 && item_s1.end_of_payload && res_v_s2 && !summary.ready;
		adv_s1        = v_s1 && !stall_s1;
		payload.ready = !stall_s1;
		summary.valid = res_v_s2;
		summary.data  = res_s2;
	end

	// Per-byte header walk; positions are relative to the current header end.
	always_comb begin
		logic [7:0]   b;
		logic         v6_nib;
		logic         mark_ok;
		logic [W-1:0] p_w;
		logic [W-1:0] he_w;
		logic [W-1:0] sk_w;

		b      = item_s1.data_byte;
		v6_nib = (b[7:4] == IPV6_VERSION);
		p_w    = W'(pos_q);
		he_w   = W'(hdr_end_q);
		sk_w   = W'(skip_q);

		n_phase      = phase_q;
		n_first_byte = first_byte_q;
		n_len_hi     = len_hi_q;
		n_len_lo     = len_lo_q;
		n_skip       = skip_q;
		n_nonce      = nonce_q;
		n_confirm    = confirm_q;
		n_origin     = origin_q;
		n_hdr_end    = hdr_end_q;
		n_auth       = auth_q;
		n_mark_bad   = mark_bad_q;
		n_v6_direct  = v6_direct_q;
		n_v6_after   = v6_after_q;
		n_nh         = nh_q;

		// Origin indication and inner packet
		if (p_w >= he_w && p_w < he_w + W'(FIELD_SPAN)) begin
			n_origin = {origin_q[39:0], b};
		end
		if ((p_w == he_w || p_w == he_w + W'(1)) && b != 8'd0) begin
			n_mark_bad = 1'b1;
		end
		mark_ok = !n_mark_bad;
		if (p_w == he_w && v6_nib) begin
			n_v6_direct = 1'b1;
		end
		if (p_w == he_w + W'(FIELD_SPAN) && mark_ok && v6_nib) begin
			n_v6_after = 1'b1;
		end
		if (p_w == he_w + W'(ORIGIN_NH_OFS) && !mark_ok) begin
			n_nh = b;
		end
		if (p_w == he_w + W'(INNER_NH_OFS) && mark_ok) begin
			n_nh = b;
		end

		// Authentication body: nonce and confirmation
		if (auth_q && phase_q == PH_BODY) begin
			if (p_w >= sk_w && p_w < sk_w + W'(FIELD_SPAN)) begin
				n_nonce = {nonce_q[55:0], b};
			end
			if (p_w == sk_w + W'(FIELD_SPAN)) begin
				n_confirm = b;
			end
		end

		// Lead-in and authentication lengths
		if (p_w == W'(0)) begin
			n_first_byte = b;
		end else if (p_w == W'(1)) begin
			if (first_byte_q == AUTH_MARK_HI && b == AUTH_MARK_LO) begin
				n_auth    = 1'b1;
				n_hdr_end = PARKED_END;
				n_phase   = PH_AUTH_LEN;
			end else begin
				n_phase = PH_BODY;
			end
		end else if (auth_q && phase_q == PH_AUTH_LEN) begin
			if (p_w == W'(2)) begin
				n_len_hi = b;
			end else if (p_w == W'(3)) begin
				// Lengths known: move the header end past the skipped bytes and
				// restart the origin and inner checks from there.
				n_len_lo    = b;
				n_skip      = 10'(AUTH_FIXED) + 10'(len_hi_q) + 10'(b);
				n_hdr_end   = n_skip + 10'(AUTH_TAIL);
				n_origin    = '0;
				n_mark_bad  = 1'b0;
				n_v6_direct = 1'b0;
				n_v6_after  = 1'b0;
				n_nh        = '0;
				n_phase     = PH_BODY;
			end
		end

		// Saturate the byte counter.
		n_pos = (pos_q != COUNT_MAX) ? pos_q + COUNT_BITS'(1) : pos_q;
	end

	// Summary for an end-marked byte, from the updated state.
	always_comb begin
		logic [W-1:0] len_w;
		logic [W-1:0] base_w;
		logic [W-1:0] ip_start_w;
		logic         auth_r;
		logic         trunc;
		logic         origin;
		logic         v6;

		len_w      = (pos_q == COUNT_MAX) ? W'(COUNT_MAX) : W'(pos_q) + W'(1);
		auth_r     = n_auth && len_w >= W'(AUTH_FIXED);
		trunc      = len_w < W'(n_skip) + W'(AUTH_TAIL);
		base_w     = auth_r ? W'(n_hdr_end) : '0;
		origin     = !n_mark_bad && len_w >= base_w + W'(FIELD_SPAN);
		ip_start_w = origin ? base_w + W'(FIELD_SPAN) : base_w;
		v6         = origin ? n_v6_after : n_v6_direct;

		res_d         = '0;
		res_d.outcome = OUT_SHORT;
		if (len_w >= W'(2)) begin
			res_d.outcome = OUT_PARSED;
			if (auth_r) begin
				res_d.auth_seen         = 1'b1;
				res_d.client_id_length  = n_len_hi;
				res_d.auth_value_length = n_len_lo;
			end
			if (auth_r && trunc) begin
				res_d.outcome = OUT_AUTH_TRUNC;
			end else begin
				if (auth_r) begin
					res_d.nonce        = n_nonce;
					res_d.confirmation = n_confirm;
				end
				if (origin) begin
					// Port and address travel inverted on the wire.
					res_d.origin_seen    = 1'b1;
					res_d.origin_port    = n_origin[47:32] ^ PORT_MASK;
					res_d.origin_address = n_origin[31:0] ^ ADDR_MASK;
				end
				if (v6) begin
					res_d.ipv6_seen = 1'b1;
					res_d.bubble    = (n_nh == NH_NO_NEXT) &&
						(len_w == ip_start_w + W'(IPV6_HDR_LEN));
				end
			end
		end
	end

	// Input stage: load whenever the stage is free or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (payload.ready) begin
			v_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.ready) begin
			item_s1 <= payload.data;
		end
	end

	// Summary register: fill on an end-marked byte, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (adv_s1 && item_s1.end_of_payload) begin
			res_v_s2 <= 1'b1;
		end else if (summary.ready) begin
			res_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.end_of_payload) begin
			res_s2 <= res_d;
		end
	end

	// Parse state: advance per byte, return to start after each payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			phase_q      <= PH_LEAD;
			first_byte_q <= '0;
			len_hi_q     <= '0;
			len_lo_q     <= '0;
			skip_q       <= '0;
			nonce_q      <= '0;
			confirm_q    <= '0;
			origin_q     <= '0;
			hdr_end_q    <= '0;
			auth_q       <= 1'b0;
			mark_bad_q   <= 1'b0;
			v6_direct_q  <= 1'b0;
			v6_after_q   <= 1'b0;
			nh_q         <= '0;
		end else if (adv_s1) begin
			if (item_s1.end_of_payload) begin
				pos_q        <= '0;
				phase_q      <= PH_LEAD;
				first_byte_q <= '0;
				len_hi_q     <= '0;
				len_lo_q     <= '0;
				skip_q       <= '0;
				nonce_q      <= '0;
				confirm_q    <= '0;
				origin_q     <= '0;
				hdr_end_q    <= '0;
				auth_q       <= 1'b0;
				mark_bad_q   <= 1'b0;
				v6_direct_q  <= 1'b0;
				v6_after_q   <= 1'b0;
				nh_q         <= '0;
			end else begin
				pos_q        <= n_pos;
				phase_q      <= n_phase;
				first_byte_q <= n_first_byte;
				len_hi_q     <= n_len_hi;
				len_lo_q     <= n_len_lo;
				skip_q       <= n_skip;
				nonce_q      <= n_nonce;
				confirm_q    <= n_confirm;
				origin_q     <= n_origin;
				hdr_end_q    <= n_hdr_end;
				auth_q       <= n_auth;
				mark_bad_q   <= n_mark_bad;
				v6_direct_q  <= n_v6_direct;
				v6_after_q   <= n_v6_after;
				nh_q         <= n_nh;
			end
		end
	end

endmodule

// ===== rtl/thp_checker.sv =====
// ----------------------------------------------------------------------------
// thp_checker
// Port-level checks of the Teredo header parser: summary hold under stall
// and the bookkeeping of payloads in flight.
// ----------------------------------------------------------------------------
module thp_checker import thp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     in_eop,
	input logic     out_valid,
	input logic     out_ready,
	input summary_t out_data
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = in_valid && in_ready && in_eop;
	assign out_xfer = out_valid && out_ready;

	// Count payloads ended but not yet summarized.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (!in_xfer && out_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("summary changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("summary without an ended payload");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more payloads in flight than stages");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 && !out_ready |-> !in_ready)
		else $error("input taken with both stages full");

endmodule

bind teredo_header_parser thp_checker u_thp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (payload.valid),
	.in_ready  (payload.ready),
	.in_eop    (payload.data.end_of_payload),
	.out_valid (summary.valid),
	.out_ready (summary.ready),
	.out_data  (summary.data)
);

// ===== test/teredo_header_parser_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// teredo_header_parser_checker
// Watches the payload and summary channels of the header parser, predicts
// one summary per end-marked byte and compares every summary field by field.
// ----------------------------------------------------------------------------
module teredo_header_parser_checker import thp_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	thp_byte_if    payload,
	thp_summary_if summary,
	output int     failures,
	output int     pending,
	output int     n_summaries,
	output int     n_short,
	output int     n_trunc,
	output int     n_auth,
	output int     n_origin,
	output int     n_bubble
);

	localparam longint unsigned COUNT_MAX    = (64'd1 << COUNT_BITS) - 64'd1;
	localparam int              REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_AUTH_LEN,
		PH_BODY
	} phase_t;

	// Parse state, mirrored from the block
	logic [COUNT_BITS-1:0] byte_idx;
	phase_t                phase;
	logic [15:0]           lead_word;
	logic [15:0]           len_word;
	logic [9:0]            nonce_start;
	logic [63:0]           nonce_sr;
	logic [7:0]            confirm_q;
	logic [63:0]           origin_sr;
	logic [9:0]            hdr_end;
	logic                  f_auth;
	logic                  f_mark_bad;
	logic                  f_v6_direct;
	logic                  f_v6_after;
	logic [7:0]            nh_byte;

	summary_t expected_summaries[$];

	task automatic reset_parse();
		byte_idx    = '0;
		phase       = PH_LEAD;
		lead_word   = '0;
		len_word    = '0;
		nonce_start = '0;
		nonce_sr    = '0;
		confirm_q   = '0;
		origin_sr   = '0;
		hdr_end     = '0;
		f_auth      = 1'b0;
		f_mark_bad  = 1'b0;
		f_v6_direct = 1'b0;
		f_v6_after  = 1'b0;
		nh_byte     = '0;
	endtask

	// Advance the parse by one byte; on an end-marked byte build the summary.
	task automatic parse_byte(input logic [7:0] b, input logic last, output bit emit,
			output summary_t s);
		longint unsigned p, he, len, base, ip_start;
		bit auth, mark_ok, origin, v6;
		p    = byte_idx;
		he   = hdr_end;
		auth = f_auth;

		if (p >= he && p < he + FIELD_SPAN)
			origin_sr = {origin_sr[55:0], b};
		if ((p == he || p == he + 1) && b != 8'h00)
			f_mark_bad = 1'b1;
		mark_ok = !f_mark_bad;
		if (p == he && b[7:4] == IPV6_VERSION)
			f_v6_direct = 1'b1;
		if (p == he + FIELD_SPAN && mark_ok && b[7:4] == IPV6_VERSION)
			f_v6_after = 1'b1;
		if (p == he + ORIGIN_NH_OFS && !mark_ok)
			nh_byte = b;
		if (p == he + INNER_NH_OFS && mark_ok)
			nh_byte = b;

		if (auth && phase == PH_BODY) begin
			if (p >= nonce_start && p < nonce_start + FIELD_SPAN)
				nonce_sr = {nonce_sr[55:0], b};
			if (p == nonce_start + FIELD_SPAN)
				confirm_q = b;
		end

		if (p == 0) begin
			lead_word = {b, 8'h00};
		end else if (p == 1) begin
			lead_word[7:0] = b;
			if (lead_word == {AUTH_MARK_HI, AUTH_MARK_LO}) begin
				f_auth  = 1'b1;
				hdr_end = PARKED_END;
				phase   = PH_AUTH_LEN;
			end else begin
				phase = PH_BODY;
			end
		end else if (auth && phase == PH_AUTH_LEN) begin
			if (p == 2) begin
				len_word = {b, 8'h00};
			end else if (p == 3) begin
				len_word[7:0] = b;
				nonce_start   = 10'(AUTH_FIXED + len_word[15:8] + len_word[7:0]);
				hdr_end       = 10'(nonce_start + AUTH_TAIL);
				origin_sr     = '0;
				f_mark_bad    = 1'b0;
				f_v6_direct   = 1'b0;
				f_v6_after    = 1'b0;
				nh_byte       = '0;
				phase         = PH_BODY;
			end
		end

		// the counter saturates on very long payloads
		if (p < COUNT_MAX)
			byte_idx = byte_idx + 1'b1;

		emit = last;
		s    = '0;
		if (!last)
			return;

		len = (p < COUNT_MAX) ? p + 1 : COUNT_MAX;
		if (len < 2) begin
			s.outcome = OUT_SHORT;
			reset_parse();
			return;
		end
		s.outcome = OUT_PARSED;
		auth = f_auth && len >= AUTH_FIXED;
		if (auth) begin
			s.auth_seen         = 1'b1;
			s.client_id_length  = len_word[15:8];
			s.auth_value_length = len_word[7:0];
			if (len < nonce_start + AUTH_TAIL) begin
				s.outcome = OUT_AUTH_TRUNC;
				reset_parse();
				return;
			end
			s.nonce        = nonce_sr;
			s.confirmation = confirm_q;
		end
		base     = auth ? hdr_end : 0;
		origin   = !f_mark_bad && len >= base + FIELD_SPAN;
		ip_start = origin ? base + FIELD_SPAN : base;
		v6       = origin ? f_v6_after : f_v6_direct;
		if (origin) begin
			s.origin_seen    = 1'b1;
			s.origin_port    = origin_sr[47:32] ^ PORT_MASK;
			s.origin_address = origin_sr[31:0] ^ ADDR_MASK;
		end
		if (v6) begin
			s.ipv6_seen = 1'b1;
			if (nh_byte == NH_NO_NEXT && len == ip_start + IPV6_HDR_LEN)
				s.bubble = 1'b1;
		end
		reset_parse();
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("[%0t] summary %s mismatch: expected %0h, got %0h", $time, what, want, got);
	endtask

	// Compare one summary transfer against the oldest prediction.
	task automatic check_summary(input summary_t got);
		summary_t want;
		if (expected_summaries.size() == 0) begin
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("[%0t] summary with no payload pending: %0h", $time, got);
			return;
		end
		want = expected_summaries.pop_front();
		if (got.outcome !== want.outcome)
			note_mismatch("outcome", want.outcome, got.outcome);
		if (got.auth_seen !== want.auth_seen)
			note_mismatch("auth_seen", want.auth_seen, got.auth_seen);
		if (got.client_id_length !== want.client_id_length)
			note_mismatch("client_id_length", want.client_id_length, got.client_id_length);
		if (got.auth_value_length !== want.auth_value_length)
			note_mismatch("auth_value_length", want.auth_value_length, got.auth_value_length);
		if (got.nonce !== want.nonce)
			note_mismatch("nonce", want.nonce, got.nonce);
		if (got.confirmation !== want.confirmation)
			note_mismatch("confirmation", want.confirmation, got.confirmation);
		if (got.origin_seen !== want.origin_seen)
			note_mismatch("origin_seen", want.origin_seen, got.origin_seen);
		if (got.origin_port !== want.origin_port)
			note_mismatch("origin_port", want.origin_port, got.origin_port);
		if (got.origin_address !== want.origin_address)
			note_mismatch("origin_address", want.origin_address, got.origin_address);
		if (got.ipv6_seen !== want.ipv6_seen)
			note_mismatch("ipv6_seen", want.ipv6_seen, got.ipv6_seen);
		if (got.bubble !== want.bubble)
			note_mismatch("bubble", want.bubble, got.bubble);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		summary_t want;
		bit       emit;
		if (!arst_n) begin
			reset_parse();
			expected_summaries.delete();
			failures    = 0;
			n_summaries = 0;
			n_short     = 0;
			n_trunc     = 0;
			n_auth      = 0;
			n_origin    = 0;
			n_bubble    = 0;
			pending    <= 0;
		end else begin
			if (summary.valid && summary.ready)
				check_summary(summary.data);
			if (payload.valid && payload.ready) begin
				parse_byte(payload.data.data_byte, payload.data.end_of_payload, emit, want);
				if (emit) begin
					expected_summaries.push_back(want);
					n_summaries++;
					if (want.outcome == OUT_SHORT)
						n_short++;
					if (want.outcome == OUT_AUTH_TRUNC)
						n_trunc++;
					if (want.auth_seen)
						n_auth++;
					if (want.origin_seen)
						n_origin++;
					if (want.bubble)
						n_bubble++;
				end
			end
			pending <= expected_summaries.size();
		end
	end

endmodule

// ===== test/teredo_header_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// teredo_header_parser_tb
// Feeds the header parser with directed and random UDP payloads (Teredo
// headers, bubbles, noise, truncations) under varying back-pressure, and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module teredo_header_parser_tb;
	import thp_pkg::*;

	localparam int         CYCLE_LIMIT  = 50_000;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 20;
	localparam logic [7:0] ORIGIN_MARK  = 8'h00;

	typedef logic [7:0] byte_list_t[$];

	logic clk;
	logic arst_n;

	thp_byte_if    payload_ch ();
	thp_summary_if summary_ch ();

	int failures, pending;
	int n_summaries, n_short, n_trunc, n_auth, n_origin, n_bubble;

	// idle rates of the two sides, in percent of cycles
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	// a flip of hold_flip asks the receiver for one long hold-off
	logic hold_flip = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	int bytes_sent    = 0;
	int payloads_sent = 0;
	int cycle_count   = 0;

	teredo_header_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload_ch),
		.summary (summary_ch)
	);

	teredo_header_parser_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.payload     (payload_ch),
		.summary     (summary_ch),
		.failures    (failures),
		.pending     (pending),
		.n_summaries (n_summaries),
		.n_short     (n_short),
		.n_trunc     (n_trunc),
		.n_auth      (n_auth),
		.n_origin    (n_origin),
		.n_bubble    (n_bubble)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Summary receiver: random stalls, plus one long hold-off on request so
	// the block fills up and has to hold an end-marked byte.
	always @(negedge clk) begin
		if (!arst_n) begin
			summary_ch.ready <= 1'b0;
		end else if (hold_flip != hold_seen) begin
			hold_seen        <= hold_flip;
			hold_left        <= HOLD_CYCLES;
			summary_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left        <= hold_left - 1;
			summary_ch.ready <= 1'b0;
		end else begin
			summary_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Offer one byte from a falling edge and hold it until the transfer.
	// Returns at the falling edge after the transfer.
	task automatic push_byte(input logic [7:0] b, input logic eop);
		while ($urandom_range(99) < src_idle_pct) begin
			payload_ch.valid <= 1'b0;
			@(negedge clk);
		end
		payload_ch.valid <= 1'b1;
		payload_ch.data  <= '{data_byte: b, end_of_payload: eop};
		@(posedge clk);
		while (!payload_ch.ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_payload(input byte_list_t bytes);
		for (int i = 0; i < bytes.size(); i++)
			push_byte(bytes[i], i == bytes.size() - 1);
		payloads_sent++;
	endtask

	// Build a Teredo payload: optional authentication header, optional origin
	// indication, then an inner packet whose first byte carries version 6.
	function automatic byte_list_t make_teredo(input bit with_auth, input int cid,
			input int avl, input bit with_origin, input int inner_len, input bit nh_bubble);
		byte_list_t q;
		logic [7:0] nh;
		if (with_auth) begin
			q.push_back(AUTH_MARK_HI);
			q.push_back(AUTH_MARK_LO);
			q.push_back(cid[7:0]);
			q.push_back(avl[7:0]);
			repeat (cid + avl + AUTH_TAIL)
				q.push_back(8'($urandom));
		end
		if (with_origin) begin
			q.push_back(ORIGIN_MARK);
			q.push_back(ORIGIN_MARK);
			repeat (FIELD_SPAN - 2)
				q.push_back(8'($urandom));
		end
		nh = 8'($urandom);
		if (nh == NH_NO_NEXT)
			nh = nh ^ 8'h01;
		if (nh_bubble)
			nh = NH_NO_NEXT;
		for (int i = 0; i < inner_len; i++) begin
			if (i == 0)
				q.push_back({IPV6_VERSION, 4'($urandom)});
			else if (i == ORIGIN_NH_OFS)
				q.push_back(nh);
			else
				q.push_back(8'($urandom));
		end
		if (q.size() == 0)
			q.push_back(8'($urandom));
		return q;
	endfunction

	// Random payloads until both the byte and the payload floors are reached.
	task automatic run_random_phase(input int min_bytes, input int min_payloads);
		byte_list_t q;
		int start_bytes, count, pick, n, cid, avl;
		start_bytes = bytes_sent;
		count       = 0;
		while (bytes_sent - start_bytes < min_bytes || count < min_payloads) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// well-formed header chain with random content
				cid = ($urandom_range(99) < 4) ? 40 : $urandom_range(4);
				avl = ($urandom_range(99) < 4) ? 40 : $urandom_range(4);
				q = make_teredo(1'($urandom_range(1)), cid, avl, $urandom_range(9) < 6,
					$urandom_range(1) ? IPV6_HDR_LEN : $urandom_range(12),
					$urandom_range(3) != 0);
				if ($urandom_range(99) < 15) begin
					n = $urandom_range(q.size(), 1);
					q = q[0:n-1];
				end
			end else if (pick < 85) begin
				// plain noise
				q.delete();
				n = $urandom_range(20, 1);
				repeat (n)
					q.push_back(8'($urandom));
			end else if (pick < 95) begin
				// a marker followed by at most seven random bytes
				q = {AUTH_MARK_HI, ($urandom_range(1) ? AUTH_MARK_LO : ORIGIN_MARK)};
				n = $urandom_range(7);
				repeat (n)
					q.push_back(8'($urandom));
			end else begin
				// one or two bytes
				q.delete();
				q.push_back($urandom_range(1) ? AUTH_MARK_HI : 8'($urandom));
				if ($urandom_range(1))
					q.push_back($urandom_range(1) ? AUTH_MARK_LO : 8'($urandom));
			end
			send_payload(q);
			count++;
		end
	endtask

	initial begin : stimulus
		byte_list_t q;
		payload_ch.valid = 1'b0;
		payload_ch.data  = '0;
		arst_n           = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase 1: sender idles a little, receiver a lot.
		src_idle_pct = 21;
		snk_idle_pct = 48;

		// single bytes: short payloads
		q = {8'hFF};
		send_payload(q);
		q = {8'h00};
		send_payload(q);
		// auth marker with fewer than four bytes
		q = {AUTH_MARK_HI, AUTH_MARK_LO};
		send_payload(q);
		q.push_back(8'h05);
		send_payload(q);
		// lengths only: authentication truncated
		q.push_back(8'h03);
		send_payload(q);
		// full chains ending in a bubble
		q = make_teredo(1, 0, 0, 0, IPV6_HDR_LEN, 1);
		send_payload(q);
		q = make_teredo(1, 1, 2, 1, IPV6_HDR_LEN, 1);
		send_payload(q);
		q = make_teredo(0, 0, 0, 1, IPV6_HDR_LEN, 1);
		send_payload(q);
		q = make_teredo(0, 0, 0, 0, IPV6_HDR_LEN, 1);
		send_payload(q);
		// origin marker with too few bytes behind it
		q = make_teredo(0, 0, 0, 1, 0, 0);
		q = q[0:4];
		send_payload(q);
		// largest lengths, cut inside the skipped bytes
		q = make_teredo(1, 255, 255, 1, IPV6_HDR_LEN, 0);
		q = q[0:29];
		send_payload(q);
		// one byte too long for a bubble
		q = make_teredo(0, 0, 0, 0, IPV6_HDR_LEN + 1, 1);
		send_payload(q);
		// cut inside the nonce
		q = make_teredo(1, 2, 1, 0, 0, 0);
		q = q[0:9];
		send_payload(q);
		// authentication header exactly complete, nothing behind it
		q = make_teredo(1, 0, 0, 0, 0, 0);
		send_payload(q);
		// all ones, then all zeros (zeros give an origin of all ones)
		q.delete();
		repeat (16)
			q.push_back(8'hFF);
		send_payload(q);
		q.delete();
		repeat (16)
			q.push_back(8'h00);
		send_payload(q);

		run_random_phase(100, 3);

		// Phase 2: the other way round.
		src_idle_pct = 48;
		snk_idle_pct = 21;
		run_random_phase(100, 3);

		// Phase 3: no idling; hold the receiver off while short payloads pile up.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_flip <= ~hold_flip;
		repeat (10) begin
			q.delete();
			repeat ($urandom_range(3, 2))
				q.push_back(8'($urandom));
			send_payload(q);
		end
		run_random_phase(100, 3);

		// Drop valid and drain the summaries still in flight.
		payload_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payloads in %0d byte transfers; %0d summaries predicted.",
			payloads_sent, bytes_sent, n_summaries);
		$display("Covered %0d short, %0d truncated auth, %0d auth, %0d origin, %0d bubbles.",
			n_short, n_trunc, n_auth, n_origin, n_bubble);
		if (failures == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
